[design/bclm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the binary clock LED matrix scan unit.
// Register indexes, reset values, field widths and pin masks; no dependencies.

package bclm_pkg;

    localparam int ADV_W   = 14;
    localparam int PHASE_W = 7;
    localparam int PINS_W  = 7;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 14;

    localparam logic [IDX_W-1:0] CFG_ADVANCE_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_BLANK_PHASE    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SCAN_PERIOD    = 2'd2;

    localparam logic [ADV_W-1:0]   ADVANCE_PERIOD_RST = 14'd10000;
    localparam logic [PHASE_W-1:0] BLANK_PHASE_RST    = 7'd20;
    localparam logic [PHASE_W-1:0] SCAN_PERIOD_RST    = 7'd100;

    localparam logic [PINS_W-1:0] ALL_PINS  = 7'h7F;
    localparam logic [PINS_W-1:0] ROW_PINS  = 7'h70;
    localparam logic [PINS_W-1:0] ROW_FIRST = 7'h10;
    localparam logic [PINS_W-1:0] COL_FIRST = 7'h01;

    localparam logic       HOUR_TENS_RST   = 1'b1;
    localparam logic [3:0] HOUR_ONES_RST   = 4'd1;
    localparam logic [2:0] MINUTE_TENS_RST = 3'd2;
    localparam logic [3:0] MINUTE_ONES_RST = 4'd3;

endpackage

[design/binary_clock_led_matrix_scan_unit.sv]
`timescale 1ns / 1ps
// Top level of the binary clock LED matrix scan unit: scan sequencer, prescaler,
// twelve-hour clock and a one-beat result register. Depends on bclm_pkg.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    tick
// out      output     out_valid / out_ready  drive_valid, pins_high, pins_low,
//                                            hour_now, minute_tens_now, minute_ones_now
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// The result of each accepted input beat appears on the output register in the
// next cycle; a new beat is taken every cycle while the output register is empty
// or being drained, so the rate is one beat per cycle.
// Reset puts the clock at 11:23 with the scan at row 0, column 0, phase 0.
// A stalled output holds its beat and blocks input until it is taken.

module binary_clock_led_matrix_scan_unit
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            tick,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            drive_valid,
    output logic [bclm_pkg::PINS_W-1:0]     pins_high,
    output logic [bclm_pkg::PINS_W-1:0]     pins_low,
    output logic [3:0]                      hour_now,
    output logic [2:0]                      minute_tens_now,
    output logic [3:0]                      minute_ones_now,

    input  logic                            cfg_we,
    input  logic [bclm_pkg::IDX_W-1:0]      cfg_index,
    input  logic [bclm_pkg::DATA_W-1:0]     cfg_data
);

    logic [bclm_pkg::ADV_W-1:0]   advance_period_reg;
    logic [bclm_pkg::PHASE_W-1:0] blank_phase_reg;
    logic [bclm_pkg::PHASE_W-1:0] scan_period_reg;

    logic [bclm_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]                   column_reg, column_next;
    logic [1:0]                   row_reg, row_next;
    logic [bclm_pkg::ADV_W-1:0]   prescale_reg, prescale_next;
    logic                         hour_tens_reg, hour_tens_next;
    logic [3:0]                   hour_ones_reg, hour_ones_next;
    logic [2:0]                   minute_tens_reg, minute_tens_next;
    logic [3:0]                   minute_ones_reg, minute_ones_next;

    logic                         out_valid_reg;
    logic                         drive_valid_reg, drive_valid_next;
    logic [bclm_pkg::PINS_W-1:0]  pins_high_reg, pins_high_next;
    logic [bclm_pkg::PINS_W-1:0]  pins_low_reg, pins_low_next;
    logic [3:0]                   hour_reg, hour_next;
    logic [2:0]                   tens_out_reg;
    logic [3:0]                   ones_out_reg;

    logic                         accept;
    logic [3:0]                   hour_value;
    logic [3:0]                   row_value;
    logic [bclm_pkg::PINS_W-1:0]  led_high;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign hour_value = hour_tens_reg ? 4'(4'd10 + hour_ones_reg) : hour_ones_reg;

    always_comb
    begin
        case (row_reg)
            2'd0:    row_value = hour_value;
            2'd1:    row_value = {1'b0, minute_tens_reg};
            2'd2:    row_value = minute_ones_reg;
            default: row_value = 4'd0;
        endcase
    end

    assign led_high = (bclm_pkg::COL_FIRST << column_reg)
                    | (bclm_pkg::ROW_PINS & ~(bclm_pkg::ROW_FIRST << row_reg));

    always_comb
    begin
        phase_next       = phase_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        prescale_next    = prescale_reg;
        hour_tens_next   = hour_tens_reg;
        hour_ones_next   = hour_ones_reg;
        minute_tens_next = minute_tens_reg;
        minute_ones_next = minute_ones_reg;
        drive_valid_next = 1'b0;
        pins_high_next   = '0;
        pins_low_next    = '0;

        if (tick)
        begin
            if (phase_reg == '0)
            begin
                drive_valid_next = 1'b1;
                pins_high_next   = led_high;
                pins_low_next    = bclm_pkg::ALL_PINS & ~led_high;
            end
            else if (phase_reg == bclm_pkg::PHASE_W'(1))
            begin
                if (!row_value[column_reg])
                begin
                    drive_valid_next = 1'b1;
                    pins_high_next   = bclm_pkg::ROW_PINS;
                    pins_low_next    = bclm_pkg::ALL_PINS & ~bclm_pkg::ROW_PINS;
                end
            end
            else if (phase_reg == blank_phase_reg)
            begin
                drive_valid_next = 1'b1;
                pins_high_next   = bclm_pkg::ROW_PINS;
                pins_low_next    = bclm_pkg::ALL_PINS & ~bclm_pkg::ROW_PINS;
            end

            if (phase_reg >= scan_period_reg)
            begin
                phase_next  = '0;
                column_next = column_reg + 2'd1;
                if (column_reg == 2'd3)
                begin
                    row_next = (row_reg >= 2'd2) ? 2'd0 : row_reg + 2'd1;
                end
            end
            else
            begin
                phase_next = phase_reg + bclm_pkg::PHASE_W'(1);
            end

            if (prescale_reg >= advance_period_reg)
            begin
                prescale_next = bclm_pkg::ADV_W'(1);
                if (minute_ones_reg >= 4'd9)
                begin
                    minute_ones_next = 4'd0;
                    if (minute_tens_reg >= 3'd5)
                    begin
                        minute_tens_next = 3'd0;
                        if (hour_tens_reg)
                        begin
                            if (hour_ones_reg >= 4'd2)
                            begin
                                hour_tens_next = 1'b0;
                                hour_ones_next = 4'd1;
                            end
                            else
                            begin
                                hour_ones_next = hour_ones_reg + 4'd1;
                            end
                        end
                        else if (hour_ones_reg >= 4'd9)
                        begin
                            hour_tens_next = 1'b1;
                            hour_ones_next = 4'd0;
                        end
                        else
                        begin
                            hour_ones_next = hour_ones_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        minute_tens_next = minute_tens_reg + 3'd1;
                    end
                end
                else
                begin
                    minute_ones_next = minute_ones_reg + 4'd1;
                end
            end
            else
            begin
                prescale_next = prescale_reg + bclm_pkg::ADV_W'(1);
            end
        end

        hour_next = hour_tens_next ? 4'(4'd10 + hour_ones_next) : hour_ones_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            advance_period_reg <= bclm_pkg::ADVANCE_PERIOD_RST;
            blank_phase_reg    <= bclm_pkg::BLANK_PHASE_RST;
            scan_period_reg    <= bclm_pkg::SCAN_PERIOD_RST;
            phase_reg          <= '0;
            column_reg         <= '0;
            row_reg            <= '0;
            prescale_reg       <= '0;
            hour_tens_reg      <= bclm_pkg::HOUR_TENS_RST;
            hour_ones_reg      <= bclm_pkg::HOUR_ONES_RST;
            minute_tens_reg    <= bclm_pkg::MINUTE_TENS_RST;
            minute_ones_reg    <= bclm_pkg::MINUTE_ONES_RST;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bclm_pkg::CFG_ADVANCE_PERIOD: advance_period_reg <= cfg_data;
                    bclm_pkg::CFG_BLANK_PHASE:
                        blank_phase_reg <= cfg_data[bclm_pkg::PHASE_W-1:0];
                    bclm_pkg::CFG_SCAN_PERIOD:
                        scan_period_reg <= cfg_data[bclm_pkg::PHASE_W-1:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                phase_reg       <= phase_next;
                column_reg      <= column_next;
                row_reg         <= row_next;
                prescale_reg    <= prescale_next;
                hour_tens_reg   <= hour_tens_next;
                hour_ones_reg   <= hour_ones_next;
                minute_tens_reg <= minute_tens_next;
                minute_ones_reg <= minute_ones_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_valid_reg <= drive_valid_next;
            pins_high_reg   <= pins_high_next;
            pins_low_reg    <= pins_low_next;
            hour_reg        <= hour_next;
            tens_out_reg    <= minute_tens_next;
            ones_out_reg    <= minute_ones_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_valid     = drive_valid_reg;
    assign pins_high       = pins_high_reg;
    assign pins_low        = pins_low_reg;
    assign hour_now        = hour_reg;
    assign minute_tens_now = tens_out_reg;
    assign minute_ones_now = ones_out_reg;

    // A beat without a new pattern carries no pins.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !drive_valid |-> pins_high == '0 && pins_low == '0)
        else $error("pins set on a beat without a pattern");

    // A new pattern drives every pin exactly one way.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_valid |->
            (pins_high & pins_low) == '0 && (pins_high | pins_low) == bclm_pkg::ALL_PINS)
        else $error("pin pattern drives a pin both ways or not at all");

    // The clock digits stay within twelve-hour range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour_now >= 4'd1 && hour_now <= 4'd12
                      && minute_tens_now <= 3'd5 && minute_ones_now <= 4'd9)
        else $error("clock digits out of range");

    // The scan row never reaches the unused fourth row.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_reg != 2'd3)
        else $error("scan row out of range");

endmodule
